// File: rtl/core/tlef_pkg.sv
`default_nettype none

package tlef_pkg;

  // Line number field: minimum printed width, and digits of the counter
  // saturation value (999999)
  localparam int NUMBER_DIGITS = 6;
  localparam int COUNT_DIGITS  = 6;
  localparam int FIELD_MAX     = (NUMBER_DIGITS > COUNT_DIGITS) ? NUMBER_DIGITS : COUNT_DIGITS;
  localparam int COL_W         = $clog2(FIELD_MAX);
  localparam int DIG_IDX_W     = $clog2(COUNT_DIGITS);
  localparam int NSIG_W        = $clog2(COUNT_DIGITS + 1);

  // Body of a run: escaped character or line end, at most four bytes
  localparam int BODY_MAX   = 4;
  localparam int BODY_IDX_W = $clog2(BODY_MAX);
  localparam int BODY_CNT_W = $clog2(BODY_MAX + 1);

  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_NONBLANK = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_MARK_LINE_ENDS  = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_EVERY    = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_SQUEEZE_BLANK   = CFG_INDEX_W'(3);
  localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_TAB_CARET  = CFG_INDEX_W'(4);
  localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_NONPRINT   = CFG_INDEX_W'(5);

  // Characters
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_CTRL_MAX = 8'd31;
  localparam logic [7:0] CH_META_LO  = 8'd128;
  localparam logic [7:0] CH_META_HI  = 8'd159;
  localparam logic [7:0] CARET_OFFSET = 8'd64;
  localparam logic [3:0] CH_DIGIT_HI = 4'h3;

  // Line counters are kept in BCD, least significant digit first
  typedef logic [COUNT_DIGITS-1:0][3:0] bcd_t;
  localparam bcd_t BCD_ONE   = bcd_t'(1);
  localparam bcd_t BCD_LIMIT = {COUNT_DIGITS{4'd9}};

  typedef struct packed {
    logic number_nonblank_lines;
    logic mark_line_ends;
    logic number_every_line;
    logic squeeze_blank_lines;
    logic show_tab_caret;
    logic show_nonprinting;
  } cfg_t;

  // One queued run: optional line number field, then the body bytes
  typedef struct packed {
    logic                              has_num;
    logic [COL_W-1:0]                  start_col;
    logic [NSIG_W-1:0]                 nsig;
    bcd_t                              digits;
    logic [BODY_MAX-1:0][7:0]          body;
    logic [BODY_IDX_W-1:0]             body_last;
  } run_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    BK_FIRST,
    BK_NUM,
    BK_TAB,
    BK_BODY
  } back_state_t;

endpackage

`default_nettype wire

// File: rtl/core/tlef_front.sv
`default_nettype none

module tlef_front (
  input  wire                    clk,
  input  wire                    rst,
  input  tlef_pkg::cfg_t         cfg,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire  [7:0]             in_byte,
  input  wire                    first_of_file,
  input  tlef_pkg::queue_status_t q_status,
  output logic                   push,
  output tlef_pkg::run_t         run
);

  // Saturating BCD increment
  function automatic tlef_pkg::bcd_t bcd_inc(tlef_pkg::bcd_t v);
    tlef_pkg::bcd_t r;
    logic carry;
    r = v;
    carry = 1'b1;
    if (v != tlef_pkg::BCD_LIMIT) begin
      for (int i = 0; i < tlef_pkg::COUNT_DIGITS; i++) begin
        if (carry) begin
          if (v[i] == 4'd9) begin
            r[i] = 4'd0;
          end else begin
            r[i] = v[i] + 4'd1;
            carry = 1'b0;
          end
        end
      end
    end
    return r;
  endfunction

  // Number of significant digits, at least one
  function automatic logic [tlef_pkg::NSIG_W-1:0] bcd_sig(tlef_pkg::bcd_t v);
    logic [tlef_pkg::NSIG_W-1:0] n;
    n = tlef_pkg::NSIG_W'(1);
    for (int i = 1; i < tlef_pkg::COUNT_DIGITS; i++) begin
      if (v[i] != 4'd0) n = tlef_pkg::NSIG_W'(i + 1);
    end
    return n;
  endfunction

  tlef_pkg::bcd_t all_cnt;
  tlef_pkg::bcd_t nb_cnt;
  logic           line_has_text;
  logic           blank_done;
  logic           at_line_start;

  tlef_pkg::bcd_t all_cnt_next;
  tlef_pkg::bcd_t nb_cnt_next;
  logic           line_has_text_next;
  logic           blank_done_next;
  logic           at_line_start_next;

  tlef_pkg::bcd_t s_all;
  tlef_pkg::bcd_t s_nb;
  logic           s_text;
  logic           s_blank;
  logic           s_start;

  logic                              accept;
  logic                              is_nl;
  logic                              not_repeat;
  logic                              use_all;
  logic                              use_nb;
  tlef_pkg::bcd_t                    num_val;
  logic [tlef_pkg::NSIG_W-1:0]       nsig;
  logic [tlef_pkg::BODY_MAX-1:0][7:0] body;
  logic [tlef_pkg::BODY_CNT_W-1:0]   cnt;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;
  assign is_nl    = (in_byte == tlef_pkg::CH_NL);

  // Line state as seen by this byte; a new file starts from reset values
  always_comb begin
    s_all   = first_of_file ? tlef_pkg::BCD_ONE : all_cnt;
    s_nb    = first_of_file ? tlef_pkg::BCD_ONE : nb_cnt;
    s_text  = first_of_file ? 1'b0 : line_has_text;
    s_blank = first_of_file ? 1'b0 : blank_done;
    s_start = first_of_file ? 1'b1 : at_line_start;
  end

  // Classify the byte: number field, body bytes, next line state
  always_comb begin
    body               = '0;
    cnt                = '0;
    not_repeat         = !cfg.squeeze_blank_lines || !s_blank;
    use_all            = 1'b0;
    use_nb             = 1'b0;
    line_has_text_next = s_text;
    blank_done_next    = s_blank;
    at_line_start_next = s_start;

    if (is_nl) begin
      use_all = cfg.number_every_line && !cfg.number_nonblank_lines && s_start && not_repeat;
      if (cfg.mark_line_ends && not_repeat) begin
        if (cfg.number_nonblank_lines && !s_text) begin
          body[cnt[tlef_pkg::BODY_IDX_W-1:0]] = tlef_pkg::CH_TAB;
          cnt = cnt + 1'b1;
        end
        body[cnt[tlef_pkg::BODY_IDX_W-1:0]] = tlef_pkg::CH_DOLLAR;
        cnt = cnt + 1'b1;
      end
      if (cfg.squeeze_blank_lines && !s_text) begin
        if (!s_blank) begin
          body[cnt[tlef_pkg::BODY_IDX_W-1:0]] = tlef_pkg::CH_NL;
          cnt = cnt + 1'b1;
          blank_done_next = 1'b1;
        end
      end else begin
        body[cnt[tlef_pkg::BODY_IDX_W-1:0]] = tlef_pkg::CH_NL;
        cnt = cnt + 1'b1;
        blank_done_next = 1'b0;
      end
      line_has_text_next = 1'b0;
      at_line_start_next = 1'b1;
    end else begin
      use_all = cfg.number_every_line && s_start && !cfg.number_nonblank_lines;
      if (use_all) at_line_start_next = 1'b0;
      use_nb = cfg.number_nonblank_lines && !s_text;
      // escaping
      if (cfg.show_tab_caret && in_byte == tlef_pkg::CH_TAB) begin
        body[0] = tlef_pkg::CH_CARET;
        body[1] = tlef_pkg::CH_I;
        cnt     = tlef_pkg::BODY_CNT_W'(2);
      end else if (cfg.show_nonprinting) begin
        if (in_byte >= tlef_pkg::CH_META_LO && in_byte <= tlef_pkg::CH_META_HI) begin
          body[0] = tlef_pkg::CH_M;
          body[1] = tlef_pkg::CH_DASH;
          body[2] = tlef_pkg::CH_CARET;
          body[3] = in_byte - tlef_pkg::CARET_OFFSET;
          cnt     = tlef_pkg::BODY_CNT_W'(4);
        end else if (in_byte <= tlef_pkg::CH_CTRL_MAX && in_byte != tlef_pkg::CH_TAB) begin
          body[0] = tlef_pkg::CH_CARET;
          body[1] = in_byte + tlef_pkg::CARET_OFFSET;
          cnt     = tlef_pkg::BODY_CNT_W'(2);
        end else if (in_byte == tlef_pkg::CH_DEL) begin
          body[0] = tlef_pkg::CH_CARET;
          body[1] = tlef_pkg::CH_QMARK;
          cnt     = tlef_pkg::BODY_CNT_W'(2);
        end else begin
          body[0] = in_byte;
          cnt     = tlef_pkg::BODY_CNT_W'(1);
        end
      end else begin
        body[0] = in_byte;
        cnt     = tlef_pkg::BODY_CNT_W'(1);
      end
      line_has_text_next = 1'b1;
      blank_done_next    = 1'b0;
    end
  end

  // Counters and the number field
  always_comb begin
    all_cnt_next = use_all ? bcd_inc(s_all) : s_all;
    nb_cnt_next  = use_nb ? bcd_inc(s_nb) : s_nb;
    num_val      = use_all ? s_all : s_nb;
    nsig         = bcd_sig(num_val);
  end

  // Run descriptor to the queue
  always_comb begin
    push          = accept && (cnt != '0);
    run.has_num   = use_all || use_nb;
    run.nsig      = nsig;
    run.digits    = num_val;
    run.body      = body;
    run.body_last = tlef_pkg::BODY_IDX_W'(cnt - 1'b1);
    if (int'(nsig) > tlef_pkg::NUMBER_DIGITS) begin
      run.start_col = tlef_pkg::COL_W'(nsig - 1'b1);
    end else begin
      run.start_col = tlef_pkg::COL_W'(tlef_pkg::NUMBER_DIGITS - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      all_cnt       <= tlef_pkg::BCD_ONE;
      nb_cnt        <= tlef_pkg::BCD_ONE;
      line_has_text <= 1'b0;
      blank_done    <= 1'b0;
      at_line_start <= 1'b1;
    end else if (accept) begin
      all_cnt       <= all_cnt_next;
      nb_cnt        <= nb_cnt_next;
      line_has_text <= line_has_text_next;
      blank_done    <= blank_done_next;
      at_line_start <= at_line_start_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tlef_queue.sv
`default_nettype none

module tlef_queue #(
  parameter int DEPTH = tlef_pkg::QUEUE_DEPTH
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     push,
  input  tlef_pkg::run_t          push_data,
  input  wire                     pop,
  output tlef_pkg::run_t          head,
  output tlef_pkg::queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tlef_pkg::run_t    entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign head         = entries[rd_ptr];
  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);

  // Storage, no reset on payload
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tlef_back.sv
`default_nettype none

module tlef_back (
  input  wire                     clk,
  input  wire                     rst,
  input  tlef_pkg::run_t          head,
  input  tlef_pkg::queue_status_t q_status,
  output logic                    pop,
  output logic                    out_valid,
  input  wire                     out_stall,
  output logic [7:0]              out_byte,
  output logic                    last_of_run
);

  tlef_pkg::back_state_t             state;
  tlef_pkg::back_state_t             state_next;
  logic [tlef_pkg::COL_W-1:0]        col;
  logic [tlef_pkg::COL_W-1:0]        col_next;
  logic [tlef_pkg::BODY_IDX_W-1:0]   idx;
  logic [tlef_pkg::BODY_IDX_W-1:0]   idx_next;

  tlef_pkg::back_state_t             phase;
  logic [tlef_pkg::COL_W-1:0]        cur_col;
  logic [tlef_pkg::BODY_IDX_W-1:0]   cur_idx;
  logic                              adv;
  logic [7:0]                        emit_byte;
  logic                              emit_last;

  // Emit a byte whenever the queue holds a run and the output register is free or being taken
  assign adv = !q_status.empty && (!out_valid || !out_stall);

  // At the start of a run, position comes from the queue head
  always_comb begin
    phase   = state;
    cur_col = col;
    cur_idx = idx;
    if (state == tlef_pkg::BK_FIRST) begin
      phase   = head.has_num ? tlef_pkg::BK_NUM : tlef_pkg::BK_BODY;
      cur_col = head.start_col;
      cur_idx = '0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    col_next   = col;
    idx_next   = idx;
    if (adv) begin
      case (phase)
        tlef_pkg::BK_NUM: begin
          if (cur_col == '0) begin
            state_next = tlef_pkg::BK_TAB;
          end else begin
            state_next = tlef_pkg::BK_NUM;
            col_next   = cur_col - 1'b1;
          end
        end
        tlef_pkg::BK_TAB: begin
          state_next = tlef_pkg::BK_BODY;
          idx_next   = '0;
        end
        tlef_pkg::BK_BODY: begin
          if (cur_idx == head.body_last) begin
            state_next = tlef_pkg::BK_FIRST;
          end else begin
            state_next = tlef_pkg::BK_BODY;
            idx_next   = cur_idx + 1'b1;
          end
        end
        default: state_next = tlef_pkg::BK_FIRST;
      endcase
    end
  end

  // Byte for the current position
  always_comb begin
    emit_byte = tlef_pkg::CH_SPACE;
    emit_last = 1'b0;
    case (phase)
      tlef_pkg::BK_NUM: begin
        // leading columns are space padding
        if (cur_col < tlef_pkg::COL_W'(head.nsig)) begin
          emit_byte = {tlef_pkg::CH_DIGIT_HI,
                       head.digits[cur_col[tlef_pkg::DIG_IDX_W-1:0]]};
        end
      end
      tlef_pkg::BK_TAB: emit_byte = tlef_pkg::CH_TAB;
      tlef_pkg::BK_BODY: begin
        emit_byte = head.body[cur_idx];
        emit_last = (cur_idx == head.body_last);
      end
      default: emit_byte = tlef_pkg::CH_SPACE;
    endcase
    pop = adv && (phase == tlef_pkg::BK_BODY) && emit_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tlef_pkg::BK_FIRST;
      col       <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      col   <= col_next;
      idx   <= idx_next;
      if (adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte    <= emit_byte;
      last_of_run <= emit_last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/text_line_number_escape_filter_core.sv
// Text filter that numbers lines, squeezes blank lines, marks line ends and
// escapes tabs, control and high bytes; one text byte in, a run of bytes out,
// the final byte of each run flagged by last_of_run. The front accepts one
// input byte per cycle while the two-entry run queue has room; the back
// emits one output byte per cycle while out_stall is low, so an input byte
// that expands to N output bytes occupies the back until all N are out (a
// numbered line adds the field width plus one byte for the tab) and the front
// stalls once the queue fills behind it. A squeezed blank line produces no
// output and pushes no run. The first output byte of a run passes through
// the run queue and then the output register. Configuration is taken on
// cfg_valid at any time (cfg_ready is always high) but must only change while
// the filter is drained; only bit 0 of the data is used and indexes past the
// last register are ignored.
`default_nettype none

module text_line_number_escape_filter_core #(
  parameter int QUEUE_DEPTH = tlef_pkg::QUEUE_DEPTH
) (
  input  wire                               clk,
  input  wire                               rst,

  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [tlef_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire                               cfg_data,

  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  [7:0]                        in_byte,
  input  wire                               first_of_file,

  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [7:0]                        out_byte,
  output logic                              last_of_run
);

  tlef_pkg::cfg_t          cfg;
  tlef_pkg::queue_status_t q_status;
  tlef_pkg::run_t          push_run;
  tlef_pkg::run_t          head_run;
  logic                    push;
  logic                    pop;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tlef_pkg::CFG_NUMBER_NONBLANK: cfg.number_nonblank_lines <= cfg_data;
        tlef_pkg::CFG_MARK_LINE_ENDS:  cfg.mark_line_ends        <= cfg_data;
        tlef_pkg::CFG_NUMBER_EVERY:    cfg.number_every_line     <= cfg_data;
        tlef_pkg::CFG_SQUEEZE_BLANK:   cfg.squeeze_blank_lines   <= cfg_data;
        tlef_pkg::CFG_SHOW_TAB_CARET:  cfg.show_tab_caret        <= cfg_data;
        tlef_pkg::CFG_SHOW_NONPRINT:   cfg.show_nonprinting      <= cfg_data;
        default: ;
      endcase
    end
  end

  tlef_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .first_of_file (first_of_file),
    .q_status      (q_status),
    .push          (push),
    .run           (push_run)
  );

  tlef_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_run),
    .pop       (pop),
    .head      (head_run),
    .status    (q_status)
  );

  tlef_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head_run),
    .q_status    (q_status),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

  // The back only retires a run that is in the queue
  assert property (@(posedge clk) disable iff (rst) pop |-> !q_status.empty)
    else $error("run retired from empty queue");

  // Retiring a run loads its final byte into the output register
  assert property (@(posedge clk) disable iff (rst) pop |=> (out_valid && last_of_run))
    else $error("run retired without final byte");

  // Any byte other than a newline always produces output
  assert property (@(posedge clk) disable iff (rst)
      (in_valid && !in_stall && in_byte != tlef_pkg::CH_NL) |-> push)
    else $error("non-newline byte produced no run");

endmodule

`default_nettype wire

// File: test/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tlef_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 45;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 6;
  localparam int unsigned LINE_LIMIT = 999999;
  // indexes past the last register; the block must ignore them
  localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_LO = CFG_SHOW_NONPRINT + 3'd1;
  localparam logic [CFG_INDEX_W-1:0] SPARE_INDEX_HI = CFG_SHOW_NONPRINT + 3'd2;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_char_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic                   cfg_data = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             in_byte = '0;
  logic                   first_of_file = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [7:0]             out_byte;
  logic                   last_of_run;

  // expected output characters, oldest first
  out_char_t  pending_chars[$];
  logic [7:0] run_bytes[$];
  out_char_t  next_char;

  // filter state as the checker sees it
  cfg_t        mode;
  int unsigned all_lines;
  int unsigned text_lines;
  bit          line_has_text;
  bit          blank_shown;
  bit          at_line_start;

  int mismatch_count = 0;
  int cycle_count = 0;
  int rx_hold = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit last_was_nl = 1'b0;

  text_line_number_escape_filter_core uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .first_of_file(first_of_file),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void restart_file();
    all_lines     = 1;
    text_lines    = 1;
    line_has_text = 1'b0;
    blank_shown   = 1'b0;
    at_line_start = 1'b1;
  endfunction

  // right-justified line number plus tab; the counter saturates
  function automatic void emit_number(input bit text_only);
    string       digits;
    int unsigned v;
    v = text_only ? text_lines : all_lines;
    if (v > LINE_LIMIT) v = LINE_LIMIT;
    digits = $sformatf("%0d", v);
    for (int i = digits.len(); i < NUMBER_DIGITS; i++) run_bytes.push_back(CH_SPACE);
    for (int i = 0; i < digits.len(); i++) run_bytes.push_back(digits[i]);
    run_bytes.push_back(CH_TAB);
    if (text_only) begin
      if (text_lines < LINE_LIMIT) text_lines++;
    end else if (all_lines < LINE_LIMIT) begin
      all_lines++;
    end
  endfunction

  // works out the output run of one accepted text byte
  function automatic void filter_char(input logic [7:0] c, input logic fof);
    bit not_repeat;
    run_bytes.delete();
    if (fof) restart_file();
    if (c == CH_NL) begin
      not_repeat = !mode.squeeze_blank_lines || !blank_shown;
      if (mode.number_every_line && !mode.number_nonblank_lines && at_line_start && not_repeat)
        emit_number(1'b0);
      if (mode.mark_line_ends && not_repeat) begin
        // blank line under non-blank numbering still gets the tab column
        if (mode.number_nonblank_lines && !line_has_text) run_bytes.push_back(CH_TAB);
        run_bytes.push_back(CH_DOLLAR);
      end
      if (mode.squeeze_blank_lines && !line_has_text) begin
        if (!blank_shown) begin
          run_bytes.push_back(CH_NL);
          blank_shown = 1'b1;
        end
      end else begin
        run_bytes.push_back(CH_NL);
        blank_shown = 1'b0;
      end
      line_has_text = 1'b0;
      at_line_start = 1'b1;
    end else begin
      if (mode.number_every_line && at_line_start && !mode.number_nonblank_lines) begin
        emit_number(1'b0);
        at_line_start = 1'b0;
      end
      if (mode.number_nonblank_lines && !line_has_text) emit_number(1'b1);
      if (mode.show_tab_caret && c == CH_TAB) begin
        run_bytes.push_back(CH_CARET);
        run_bytes.push_back(CH_I);
      end else if (mode.show_nonprinting) begin
        if (c >= CH_META_LO && c <= CH_META_HI) begin
          run_bytes.push_back(CH_M);
          run_bytes.push_back(CH_DASH);
          run_bytes.push_back(CH_CARET);
          run_bytes.push_back(c - CARET_OFFSET);
        end else if (c <= CH_CTRL_MAX && c != CH_TAB && c != CH_NL) begin
          run_bytes.push_back(CH_CARET);
          run_bytes.push_back(c + CARET_OFFSET);
        end else if (c == CH_DEL) begin
          run_bytes.push_back(CH_CARET);
          run_bytes.push_back(CH_QMARK);
        end else begin
          run_bytes.push_back(c);
        end
      end else begin
        run_bytes.push_back(c);
      end
      line_has_text = 1'b1;
      blank_shown   = 1'b0;
    end
    foreach (run_bytes[i])
      pending_chars.push_back('{ch: run_bytes[i], last: (i == run_bytes.size() - 1)});
  endfunction

  // text-like byte: mostly printable, with line ends, blank runs, tabs and escapes
  function automatic void pick_text_char(output logic [7:0] c, output logic fof);
    int r;
    r = $urandom_range(0, 99);
    if (last_was_nl && $urandom_range(0, 2) == 0) c = CH_NL;
    else if (r < 14) c = CH_NL;
    else if (r < 20) c = CH_TAB;
    else if (r < 26) c = 8'($urandom_range(0, 31));
    else if (r < 31) c = 8'($urandom_range(127, 159));
    else if (r < 38) c = 8'($urandom_range(0, 255));
    else c = 8'($urandom_range(32, 126));
    fof = ($urandom_range(0, 39) == 0);
    last_was_nl = (c == CH_NL);
  endfunction

  // one text byte transfer; valid stays up so the next call can follow directly
  task automatic send_char(input logic [7:0] c, input logic fof);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= c;
    first_of_file <= fof;
    do @(posedge clk); while (in_stall);
    filter_char(c, fof);
  endtask

  // stop sending and wait until every expected byte is out
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_NUMBER_NONBLANK: mode.number_nonblank_lines = val;
      CFG_MARK_LINE_ENDS:  mode.mark_line_ends        = val;
      CFG_NUMBER_EVERY:    mode.number_every_line     = val;
      CFG_SQUEEZE_BLANK:   mode.squeeze_blank_lines   = val;
      CFG_SHOW_TAB_CARET:  mode.show_tab_caret        = val;
      CFG_SHOW_NONPRINT:   mode.show_nonprinting      = val;
      default: ;
    endcase
  endtask

  task automatic load_mode(input cfg_t m);
    settle();
    cfg_write(CFG_NUMBER_NONBLANK, m.number_nonblank_lines);
    cfg_write(CFG_MARK_LINE_ENDS,  m.mark_line_ends);
    cfg_write(CFG_NUMBER_EVERY,    m.number_every_line);
    cfg_write(CFG_SQUEEZE_BLANK,   m.squeeze_blank_lines);
    cfg_write(CFG_SHOW_TAB_CARET,  m.show_tab_caret);
    cfg_write(CFG_SHOW_NONPRINT,   m.show_nonprinting);
    cfg_valid <= 1'b0;
  endtask

  // output side: check each transfer, then hold stall for a random count unless rx_steady is set
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_chars.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected output: byte %02h last=%0b", out_byte, last_of_run);
        end else begin
          next_char = pending_chars.pop_front();
          if (next_char.ch !== out_byte || next_char.last !== last_of_run) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("output mismatch: expected byte %02h last=%0b, got byte %02h last=%0b",
                       next_char.ch, next_char.last, out_byte, last_of_run);
          end
        end
        rx_hold = rx_steady ? 0 : $urandom_range(0, 6);
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      out_stall <= (rx_hold != 0);
    end
  end

  // all options on: non-blank numbering wins, escapes, squeeze, blank line "\t$\n"
  task automatic test_both_numbering_modes();
    load_mode('1);
    send_char(8'h61, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(CH_TAB, 1'b0);
    send_char(CH_DEL, 1'b0);
    send_char(CH_META_LO, 1'b0);
    send_char(CH_META_HI, 1'b0);
    send_char(8'hA0, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_CTRL_MAX, 1'b0);
    send_char(CH_NL, 1'b0);
    send_char(CH_NL, 1'b0);
    send_char(CH_NL, 1'b0);   // squeezed away, no output
    send_char(8'h62, 1'b1);   // new file restarts the count
    send_char(CH_NL, 1'b0);
  endtask

  // every line numbered, line ends marked, raw tabs and control bytes
  task automatic test_every_line_numbering();
    cfg_t m;
    m = '0;
    m.mark_line_ends    = 1'b1;
    m.number_every_line = 1'b1;
    load_mode(m);
    send_char(CH_TAB, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(CH_NL, 1'b0);
    send_char(CH_NL, 1'b0);
    send_char(CH_META_LO, 1'b1);
    send_char(CH_NL, 1'b0);
  endtask

  // writes past the last register leave the mode alone
  task automatic test_spare_register_index();
    settle();
    cfg_write(SPARE_INDEX_LO, 1'b1);
    cfg_write(SPARE_INDEX_HI, 1'b1);
    cfg_valid <= 1'b0;
    send_char(8'h78, 1'b0);
    send_char(CH_NL, 1'b0);
    send_char(CH_DEL, 1'b0);
  endtask

  // text streams under a range of modes, the two extremes first
  task automatic test_random_text();
    cfg_t       m;
    logic [7:0] c;
    logic       fof;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       m = '0;
        1:       m = '1;
        default: m = cfg_t'($urandom_range(0, 63));
      endcase
      tx_steady = (p % 3 == 1);
      rx_steady = (p % 4 == 2);
      load_mode(m);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // on even phases the sender waits out the backlog mid-stream
        if (k == PHASE_ITEMS / 2 && p % 2 == 0) settle();
        pick_text_char(c, fof);
        send_char(c, fof);
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    mode = '0;
    restart_file();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_both_numbering_modes();
    test_every_line_numbering();
    test_spare_register_index();
    test_random_text();
    settle();
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
